@@ design/lps_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lps_pkg: shared types and pattern tables for the LED pattern sequencer
// Constants, config/result structs and the per-pattern lookup functions.
// ----------------------------------------------------------------------------
package lps_pkg;

    localparam int LED_COUNT   = 6;
    localparam int TICK_W      = 16;
    localparam int PHASE_W     = 4;
    localparam int CFG_IDX_W   = 2;

    localparam logic [TICK_W-1:0] START_TICKS_RST = 16'd500;
    localparam logic [TICK_W-1:0] SLOW_TICKS_RST  = 16'd600;
    localparam logic [TICK_W-1:0] FAST_TICKS_RST  = 16'd300;
    localparam logic [TICK_W-1:0] PAUSE_TICKS_RST = 16'd200;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_START_TICKS = 2'd0,
        CFG_SLOW_TICKS  = 2'd1,
        CFG_FAST_TICKS  = 2'd2,
        CFG_PAUSE_TICKS = 2'd3
    } cfg_idx_t;

    // pattern selects
    typedef enum logic [1:0] {
        PAT_ALT  = 2'd0,
        PAT_WALK = 2'd1,
        PAT_WAVE = 2'd2,
        PAT_BAR  = 2'd3
    } pat_t;

    // speed modes
    typedef enum logic [1:0] {
        SPD_START = 2'd0,
        SPD_SLOW  = 2'd1,
        SPD_FAST  = 2'd2,
        SPD_SPARE = 2'd3
    } spd_t;

    typedef struct packed {
        logic [TICK_W-1:0] start_ticks;
        logic [TICK_W-1:0] slow_ticks;
        logic [TICK_W-1:0] fast_ticks;
        logic [TICK_W-1:0] pause_ticks;
    } cfg_t;

    typedef struct packed {
        logic [LED_COUNT-1:0] led_bits;
        logic                 running;
    } result_t;

    // number of phases in each pattern (bar includes the pause phase)
    function automatic logic [PHASE_W-1:0] phase_total(input pat_t pat);
        logic [PHASE_W-1:0] n;
        case (pat)
            PAT_ALT:  n = PHASE_W'(2);
            PAT_WALK: n = PHASE_W'(2 * LED_COUNT);
            PAT_WAVE: n = PHASE_W'(4);
            default:  n = PHASE_W'(LED_COUNT + 1);
        endcase
        return n;
    endfunction

    function automatic logic [LED_COUNT-1:0] pattern_bits(input pat_t pat,
                                                         input logic [PHASE_W-1:0] ph);
        logic [LED_COUNT-1:0] b;
        b = '0;
        if (ph < phase_total(pat))
        begin
            case (pat)
                PAT_ALT:  b = ph[0] ? 6'h15 : 6'h2A;
                PAT_WALK: b = ph[0] ? '0 : LED_COUNT'(1) << ph[PHASE_W-1:1];
                PAT_WAVE:
                begin
                    case (ph[1:0])
                        2'd0:    b = 6'h21;
                        2'd2:    b = 6'h0C;
                        default: b = 6'h12;
                    endcase
                end
                default:
                begin
                    // bar fill; phase LED_COUNT is the blank pause
                    if (ph < PHASE_W'(LED_COUNT))
                        b = ~(LED_COUNT'('1) << (ph + PHASE_W'(1)));
                end
            endcase
        end
        return b;
    endfunction

endpackage

@@ design/lps_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lps_ctrl: button edge decode, mode state and phase timer
// Updates all sequencer state on each accepted tick and forms its result.
// ----------------------------------------------------------------------------
module lps_ctrl
    import lps_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        tick_fire,
    input  logic [2:0]  levels,     // bit0 power, bit1 select, bit2 speed
    input  cfg_t        cfg,
    output result_t     result
);

    logic               enabled_reg,     enabled_next;
    pat_t               pattern_sel_reg, pattern_sel_next;
    spd_t               speed_mode_reg,  speed_mode_next;
    logic [PHASE_W-1:0] phase_reg,       phase_next;
    logic [TICK_W-1:0]  phase_count_reg, phase_count_next;
    logic [2:0]         prev_levels_reg;

    logic [2:0]         falls;
    logic [2:0]         rises;
    logic               change;
    logic [PHASE_W-1:0] ph;
    logic [TICK_W-1:0]  cnt;
    logic [TICK_W-1:0]  len_raw;
    logic [TICK_W-1:0]  len;
    logic [PHASE_W-1:0] total;

    assign falls = prev_levels_reg & ~levels;
    assign rises = ~prev_levels_reg & levels;

    always_comb
    begin
        enabled_next     = enabled_reg;
        pattern_sel_next = pattern_sel_reg;
        speed_mode_next  = speed_mode_reg;
        change           = 1'b0;

        // power toggle wins; select beats speed
        if (falls[0])
        begin
            enabled_next = ~enabled_reg;
            change       = 1'b1;
        end
        else if (enabled_reg)
        begin
            if (rises[1])
            begin
                pattern_sel_next = pat_t'(pattern_sel_reg + 2'd1);
                change           = 1'b1;
            end
            else if (rises[2])
            begin
                speed_mode_next = (speed_mode_reg == SPD_SLOW) ? SPD_FAST : SPD_SLOW;
                change          = 1'b1;
            end
        end

        ph  = change ? '0 : phase_reg;
        cnt = change ? '0 : phase_count_reg;

        if (pattern_sel_next == PAT_BAR && ph == PHASE_W'(LED_COUNT))
            len_raw = cfg.pause_ticks;
        else if (speed_mode_next == SPD_SLOW)
            len_raw = cfg.slow_ticks;
        else if (speed_mode_next == SPD_FAST)
            len_raw = cfg.fast_ticks;
        else
            len_raw = cfg.start_ticks;
        len = (len_raw == '0) ? TICK_W'(1) : len_raw;

        total = phase_total(pattern_sel_next);

        phase_next       = ph;
        phase_count_next = cnt;
        result.led_bits  = '0;
        result.running   = enabled_next;
        if (enabled_next)
        begin
            result.led_bits = pattern_bits(pattern_sel_next, ph);
            if ({1'b0, cnt} + 17'd1 >= {1'b0, len})
            begin
                phase_count_next = '0;
                phase_next = ({1'b0, ph} + 5'd1 >= {1'b0, total}) ? '0
                                                                  : ph + PHASE_W'(1);
            end
            else
            begin
                phase_count_next = cnt + TICK_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enabled_reg     <= 1'b0;
            pattern_sel_reg <= PAT_ALT;
            speed_mode_reg  <= SPD_START;
            phase_reg       <= '0;
            phase_count_reg <= '0;
            prev_levels_reg <= 3'b111;
        end
        else if (tick_fire)
        begin
            enabled_reg     <= enabled_next;
            pattern_sel_reg <= pattern_sel_next;
            speed_mode_reg  <= speed_mode_next;
            phase_reg       <= phase_next;
            phase_count_reg <= phase_count_next;
            prev_levels_reg <= levels;
        end
    end

    // off: timer parked at phase 0
    a_off_parked: assert property (@(posedge clk) disable iff (!rst_n)
        !enabled_reg |-> (phase_reg == '0 && phase_count_reg == '0))
        else $error("phase timer moved while off");

    // phase stays inside the current pattern
    a_phase_range: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg < phase_total(pattern_sel_reg))
        else $error("phase out of range for pattern");

    // a speed release only ever lands in slow or fast
    a_speed_mode: assert property (@(posedge clk) disable iff (!rst_n)
        $past(tick_fire) && $changed(speed_mode_reg) |->
            (speed_mode_reg == SPD_SLOW || speed_mode_reg == SPD_FAST))
        else $error("bad speed mode step");

endmodule

@@ design/lps_out_buf.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lps_out_buf: two-entry result buffer
// Output register plus skid entry; input is held off only when both are full.
// ----------------------------------------------------------------------------
module lps_out_buf
    import lps_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    push,
    input  result_t push_data,
    output logic    full,
    output logic    out_valid,
    input  logic    out_stall,
    output result_t out_data
);

    logic    head_valid_reg;
    logic    skid_valid_reg;
    result_t head_reg;
    result_t skid_reg;
    logic    pop;

    assign pop       = head_valid_reg && !out_stall;
    assign full      = skid_valid_reg;
    assign out_valid = head_valid_reg;
    assign out_data  = head_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (pop)
                skid_valid_reg <= 1'b0;
        end
        else if (head_valid_reg && !pop)
        begin
            if (push)
                skid_valid_reg <= 1'b1;
        end
        else
        begin
            head_valid_reg <= push;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (pop)
                head_reg <= skid_reg;
        end
        else if (head_valid_reg && !pop)
        begin
            if (push)
                skid_reg <= push_data;
        end
        else if (push)
        begin
            head_reg <= push_data;
        end
    end

    a_skid_behind_head: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> head_valid_reg)
        else $error("skid entry valid with empty head");

    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> !push)
        else $error("transfer taken while buffer full");

    a_skid_drains: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg && pop |=> head_valid_reg && !skid_valid_reg)
        else $error("skid entry lost on drain");

endmodule

@@ design/led_pattern_sequencer_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// led_pattern_sequencer_unit: six-LED chaser with power/select/speed buttons
// One input transfer per sample tick, one result transfer per tick.
// ----------------------------------------------------------------------------
// Each input transfer is one sample tick carrying three active-low button
// levels. A power press (falling edge) toggles the sequencer; while on, a
// select release steps through the four patterns and a speed release moves
// the phase length start -> slow, then toggles slow/fast. Any change restarts
// at phase 0. Every tick yields exactly one result (led_bits, running) in the
// same order. Throughput is one tick per clock: all state update and pattern
// lookup is one combinational pass from the state registers into a two-entry
// result buffer, so a tick is taken every cycle while the buffer has room;
// each result is registered in the buffer's head or skid entry. in_stall rises
// only when the result side has stalled long enough to fill both buffer
// entries. Config registers (0 start, 1 slow, 2 fast, 3 pause ticks; zero is
// treated as one) are written through cfg_we/cfg_index/cfg_data and should be
// changed only while no tick is in flight.
// ----------------------------------------------------------------------------
module led_pattern_sequencer_unit
    import lps_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    // tick input channel
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic                 power_level,
    input  logic                 select_level,
    input  logic                 speed_level,
    // result channel
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [LED_COUNT-1:0] led_bits,
    output logic                 running,
    // config write port
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [TICK_W-1:0]    cfg_data
);

    cfg_t    cfg_reg;
    logic    tick_fire;
    logic    buf_full;
    result_t tick_result;
    result_t out_data;

    // config registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.start_ticks <= START_TICKS_RST;
            cfg_reg.slow_ticks  <= SLOW_TICKS_RST;
            cfg_reg.fast_ticks  <= FAST_TICKS_RST;
            cfg_reg.pause_ticks <= PAUSE_TICKS_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_START_TICKS: cfg_reg.start_ticks <= cfg_data;
                CFG_SLOW_TICKS:  cfg_reg.slow_ticks  <= cfg_data;
                CFG_FAST_TICKS:  cfg_reg.fast_ticks  <= cfg_data;
                CFG_PAUSE_TICKS: cfg_reg.pause_ticks <= cfg_data;
                default: ;
            endcase
        end
    end

    // tick transfer: accepted whenever the result buffer is not full
    assign in_stall  = buf_full;
    assign tick_fire = in_valid && !buf_full;

    lps_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .tick_fire (tick_fire),
        .levels    ({speed_level, select_level, power_level}),
        .cfg       (cfg_reg),
        .result    (tick_result)
    );

    lps_out_buf u_out_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (tick_fire),
        .push_data (tick_result),
        .full      (buf_full),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    assign led_bits = out_data.led_bits;
    assign running  = out_data.running;

endmodule

@@ test/lps_frame_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lps_frame_checker: expected LED frames for the LED pattern sequencer
// Tracks register writes and tick transfers, predicts each result frame and
// compares it with the result transfers in order.
// ----------------------------------------------------------------------------
module lps_frame_checker
    import lps_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic                 in_stall,
    input  logic                 power_level,
    input  logic                 select_level,
    input  logic                 speed_level,
    input  logic                 out_valid,
    input  logic                 out_stall,
    input  logic [LED_COUNT-1:0] led_bits,
    input  logic                 running,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [TICK_W-1:0]    cfg_data,
    output int                   mismatches,
    output int                   frames_pending
);

    // register copies
    logic [TICK_W-1:0]  start_len;
    logic [TICK_W-1:0]  slow_len;
    logic [TICK_W-1:0]  fast_len;
    logic [TICK_W-1:0]  pause_len;

    // sequencer state copy
    logic               sq_on;
    pat_t               sq_pat;
    spd_t               sq_spd;
    logic [PHASE_W-1:0] sq_phase;
    logic [TICK_W-1:0]  sq_count;
    logic [2:0]         sq_levels;      // {speed, select, power}

    result_t            frames_due[$];

    function automatic int phases_in(input pat_t p);
        case (p)
            PAT_ALT:  return 2;
            PAT_WALK: return 2 * LED_COUNT;
            PAT_WAVE: return 4;
            default:  return LED_COUNT + 1;
        endcase
    endfunction

    function automatic logic [LED_COUNT-1:0] frame_of(input pat_t p, input int ph);
        if (ph >= phases_in(p))
            return '0;
        case (p)
            PAT_ALT:
                return (ph % 2) ? 6'h15 : 6'h2A;
            PAT_WALK:
                return (ph % 2) ? '0 : LED_COUNT'(1 << (ph / 2));
            PAT_WAVE:
            begin
                if (ph == 0)
                    return 6'h21;
                else if (ph == 2)
                    return 6'h0C;
                else
                    return 6'h12;
            end
            default:
                // last bar phase is the blank pause
                return (ph == LED_COUNT) ? '0 : LED_COUNT'((1 << (ph + 1)) - 1);
        endcase
    endfunction

    function automatic int phase_len();
        int n;
        if (sq_pat == PAT_BAR && sq_phase == PHASE_W'(LED_COUNT))
            n = pause_len;
        else if (sq_spd == SPD_SLOW)
            n = slow_len;
        else if (sq_spd == SPD_FAST)
            n = fast_len;
        else
            n = start_len;
        return (n == 0) ? 1 : n;
    endfunction

    // one sample tick: edge detect, state update, frame for this tick
    function automatic result_t next_frame(input logic [2:0] lv);
        logic [2:0] falls;
        logic [2:0] rises;
        logic       restart;
        result_t    r;
        falls     = sq_levels & ~lv;
        rises     = ~sq_levels & lv;
        restart   = 1'b0;
        r         = '0;
        sq_levels = lv;
        if (falls[0])
        begin
            sq_on   = ~sq_on;
            restart = 1'b1;
        end
        else if (sq_on)
        begin
            if (rises[1])
            begin
                sq_pat  = (sq_pat == PAT_BAR) ? PAT_ALT : pat_t'(sq_pat + 2'd1);
                restart = 1'b1;
            end
            else if (rises[2])
            begin
                sq_spd  = (sq_spd == SPD_SLOW) ? SPD_FAST : SPD_SLOW;
                restart = 1'b1;
            end
        end
        if (restart)
        begin
            sq_phase = '0;
            sq_count = '0;
        end
        if (sq_on)
        begin
            r.led_bits = frame_of(sq_pat, sq_phase);
            if (sq_count + 1 >= phase_len())
            begin
                sq_count = '0;
                sq_phase = (sq_phase + 1 >= phases_in(sq_pat)) ? '0 : sq_phase + 1'b1;
            end
            else
                sq_count = sq_count + 1'b1;
        end
        r.running = sq_on;
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        result_t want;
        if (!rst_n)
        begin
            start_len      = START_TICKS_RST;
            slow_len       = SLOW_TICKS_RST;
            fast_len       = FAST_TICKS_RST;
            pause_len      = PAUSE_TICKS_RST;
            sq_on          = 1'b0;
            sq_pat         = PAT_ALT;
            sq_spd         = SPD_START;
            sq_phase       = '0;
            sq_count       = '0;
            sq_levels      = 3'b111;
            mismatches     = 0;
            frames_pending = 0;
            frames_due.delete();
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_START_TICKS: start_len = cfg_data;
                    CFG_SLOW_TICKS:  slow_len  = cfg_data;
                    CFG_FAST_TICKS:  fast_len  = cfg_data;
                    CFG_PAUSE_TICKS: pause_len = cfg_data;
                    default: ;
                endcase
            end
            if (in_valid && !in_stall)
                frames_due.push_back(next_frame({speed_level, select_level, power_level}));
            if (out_valid && !out_stall)
            begin
                if (frames_due.size() == 0)
                begin
                    if (mismatches < 10)
                        $display("[%0t] lps: result transfer with nothing pending: %s",
                                 $time, $sformatf("led %h run %b", led_bits, running));
                    mismatches++;
                end
                else
                begin
                    want = frames_due.pop_front();
                    if (led_bits !== want.led_bits || running !== want.running)
                    begin
                        if (mismatches < 10)
                            $display("[%0t] lps: frame mismatch led exp %h got %h, %s",
                                     $time, want.led_bits, led_bits,
                                     $sformatf("run exp %b got %b", want.running, running));
                        mismatches++;
                    end
                end
            end
            frames_pending = frames_due.size();
        end
    end

endmodule

@@ test/tb_led_pattern_sequencer_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_led_pattern_sequencer_unit: bench for the six-LED pattern sequencer
// Drives button ticks and register settings, stalls the result side at
// random; the frame checker predicts and compares every result transfer.
// ----------------------------------------------------------------------------
module tb_led_pattern_sequencer_unit;
    import lps_pkg::*;

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_stall;
    logic                 power_level;
    logic                 select_level;
    logic                 speed_level;
    logic                 out_valid;
    logic                 out_stall;
    logic [LED_COUNT-1:0] led_bits;
    logic                 running;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [TICK_W-1:0]    cfg_data;

    int                   mismatches;
    int                   frames_pending;

    // sender bookkeeping
    int                   ticks_sent = 0;
    bit                   tx_burst   = 1'b0;   // no gaps while set
    logic [2:0]           btn_lv     = 3'b111; // {speed, select, power}, 0 = pressed

    // Directed ticks, {speed, select, power}. Registers are 1/2/1/3 here so
    // phases move every one to three ticks. Covers: select release while off,
    // power on, speed start->slow->fast, select through walk and wave,
    // select+speed released together (select wins), bar fill into the pause,
    // a speed change inside the pause, and a power press in the same tick as
    // a select release (release dropped).
    logic [2:0] directed_ticks [26] = '{
        3'b101, 3'b111, 3'b110, 3'b111, 3'b111, 3'b011, 3'b111, 3'b011,
        3'b111, 3'b101, 3'b111, 3'b101, 3'b111, 3'b001, 3'b111, 3'b111,
        3'b111, 3'b111, 3'b111, 3'b111, 3'b111, 3'b011, 3'b111, 3'b101,
        3'b110, 3'b111
    };

    led_pattern_sequencer_unit dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .power_level  (power_level),
        .select_level (select_level),
        .speed_level  (speed_level),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .led_bits     (led_bits),
        .running      (running),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    lps_frame_checker u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .power_level    (power_level),
        .select_level   (select_level),
        .speed_level    (speed_level),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .led_bits       (led_bits),
        .running        (running),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .mismatches     (mismatches),
        .frames_pending (frames_pending)
    );

    // 100 MHz
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // One tick transfer. Random idle gap first (none while in a burst
    // stretch), then hold valid until the transfer. in_stall is looked at on
    // the falling edge, where it is settled for the next rising edge.
    task automatic send_tick(input logic [2:0] lv);
        int gap;
        if (ticks_sent % 50 == 0)
            tx_burst = ($urandom_range(0, 3) == 0);
        gap = tx_burst ? 0 : $urandom_range(0, 8);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid     <= 1'b1;
        power_level  <= lv[0];
        select_level <= lv[1];
        speed_level  <= lv[2];
        do @(negedge clk); while (in_stall);
        @(posedge clk);
        ticks_sent++;
    endtask

    // Mostly held levels with occasional press/release, so the sequencer
    // stays on for long runs and walks through patterns and speeds; about
    // one tick in twenty is pure noise on all three buttons.
    task automatic random_ticks(input int n);
        repeat (n)
        begin
            if ($urandom_range(0, 19) == 0)
                btn_lv = 3'($urandom_range(0, 7));
            else
            begin
                if ($urandom_range(0, 29) == 0)
                    btn_lv[0] = ~btn_lv[0];
                if ($urandom_range(0, 7) == 0)
                    btn_lv[1] = ~btn_lv[1];
                if ($urandom_range(0, 9) == 0)
                    btn_lv[2] = ~btn_lv[2];
            end
            send_tick(btn_lv);
        end
    endtask

    // Stop offering and wait until every expected frame has come back.
    task automatic drain();
        in_valid <= 1'b0;
        do @(negedge clk); while (frames_pending != 0);
        @(posedge clk);
    endtask

    // Write all four registers on back-to-back cycles; block is idle here.
    task automatic set_regs(input logic [TICK_W-1:0] start_t, input logic [TICK_W-1:0] slow_t,
                            input logic [TICK_W-1:0] fast_t, input logic [TICK_W-1:0] pause_t);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_START_TICKS;
        cfg_data  <= start_t;
        @(posedge clk);
        cfg_index <= CFG_SLOW_TICKS;
        cfg_data  <= slow_t;
        @(posedge clk);
        cfg_index <= CFG_FAST_TICKS;
        cfg_data  <= fast_t;
        @(posedge clk);
        cfg_index <= CFG_PAUSE_TICKS;
        cfg_data  <= pause_t;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    // Result side: random stall before each transfer, with no-stall stretches.
    // Twice it holds off for a long stretch so the two-entry buffer fills and
    // the block pushes back on the tick side.
    initial
    begin
        int  gap;
        int  taken;
        bit  rx_burst;
        out_stall = 1'b0;
        taken     = 0;
        rx_burst  = 1'b0;
        forever
        begin
            if (taken % 50 == 0)
                rx_burst = ($urandom_range(0, 3) == 0);
            if (taken == 400 || taken == 900)
                gap = 120;
            else
                gap = rx_burst ? 0 : $urandom_range(0, 8);
            if (gap > 0)
            begin
                out_stall <= 1'b1;
                repeat (gap) @(posedge clk);
            end
            out_stall <= 1'b0;
            do @(negedge clk); while (!out_valid);
            @(posedge clk);
            taken++;
        end
    end

    // Stimulus and verdict
    initial
    begin
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        power_level  = 1'b1;
        select_level = 1'b1;
        speed_level  = 1'b1;
        cfg_we       = 1'b0;
        cfg_index    = CFG_START_TICKS;
        cfg_data     = '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed pass from the reset state
        set_regs(16'd1, 16'd2, 16'd1, 16'd3);
        foreach (directed_ticks[i])
            send_tick(directed_ticks[i]);
        btn_lv = 3'b111;
        drain();

        // random passes over a spread of register settings
        set_regs(16'd500, 16'd600, 16'd300, 16'd200);   // power-on values
        random_ticks(150);
        drain();
        set_regs(16'd2, 16'd3, 16'd1, 16'd2);
        random_ticks(180);
        drain();
        set_regs(16'd1, 16'd1, 16'd1, 16'd1);           // every tick a new phase
        random_ticks(180);
        drain();
        set_regs(16'd0, 16'd0, 16'd0, 16'd0);           // zero acts as one
        random_ticks(120);
        drain();
        set_regs(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        random_ticks(120);
        drain();
        set_regs(16'hFFFF, 16'd1, 16'd2, 16'hFFFF);     // start and pause at the longest length
        random_ticks(150);
        drain();
        set_regs(16'($urandom_range(1, 6)), 16'($urandom_range(1, 6)),
                 16'($urandom_range(1, 6)), 16'($urandom_range(1, 6)));
        random_ticks(180);
        drain();
        set_regs(16'd3, 16'd1, 16'hFFFF, 16'd1);
        random_ticks(150);
        drain();

        // let any stray result show up before the verdict
        repeat (5) @(posedge clk);
        if (mismatches == 0 && frames_pending == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    // watchdog, far above the slowest legal run
    initial
    begin
        #2_000_000;
        $display("tb: failure");
        $finish;
    end

endmodule
